>>> hdl/artm_pkg.sv
// shared types and constants for the allocation rate trigger monitor
// used by artm_regs, artm_ctrl, artm_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package artm_pkg;

  localparam int COUNT_WIDTH_DEF = 48;
  localparam int MS_PER_S = 1000;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int OUT_FIELD_W = 48;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic [OUT_FIELD_W-1:0] OUT_MAX = '1;

  // register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_BYTES_TH = 3'd0;
  localparam logic [2:0] REG_CALLS_TH = 3'd1;
  localparam logic [2:0] REG_ALPHA    = 3'd2;
  localparam logic [2:0] REG_FACTOR   = 3'd3;
  localparam logic [2:0] REG_WINDOW   = 3'd4;

  localparam logic [47:0] BYTES_TH_RST = 48'd1048576;
  localparam logic [47:0] CALLS_TH_RST = 48'd1024;
  localparam logic [16:0] ALPHA_RST    = 17'd32768;
  localparam logic [15:0] FACTOR_RST   = 16'd512;
  localparam logic [15:0] WINDOW_RST   = 16'd16;

  typedef struct packed {
    logic [47:0] bytes_th;
    logic [47:0] calls_th;
    logic [16:0] alpha;
    logic [15:0] factor;
    logic [15:0] window_updates;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_INST_B_ALPHA,
    MUL_SMOOTH_B_BETA,
    MUL_INST_C_ALPHA,
    MUL_SMOOTH_C_BETA,
    MUL_SMOOTH_B_FACTOR,
    MUL_SMOOTH_C_FACTOR
  } mul_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     apply;
    logic     div_load;
    logic     div_step;
    logic     inst_store;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     smooth_b_store;
    logic     smooth_c_store;
    logic     close_win;
    logic     peak_store;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic close_due;
    logic out_free;
  } ctl_status_t;

endpackage

`default_nettype wire

>>> hdl/artm_regs.sv
// configuration registers behind the apb-style port
// depends on artm_pkg
`timescale 1ns / 1ps
`default_nettype none

module artm_regs
  import artm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_th       <= BYTES_TH_RST;
      cfg.calls_th       <= CALLS_TH_RST;
      cfg.alpha          <= ALPHA_RST;
      cfg.factor         <= FACTOR_RST;
      cfg.window_updates <= WINDOW_RST;
    end else if (wr) begin
      case (idx)
        REG_BYTES_TH: cfg.bytes_th       <= pwdata[47:0];
        REG_CALLS_TH: cfg.calls_th       <= pwdata[47:0];
        REG_ALPHA:    cfg.alpha          <= pwdata[16:0];
        REG_FACTOR:   cfg.factor         <= pwdata[15:0];
        REG_WINDOW:   cfg.window_updates <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BYTES_TH: prdata = CFG_DATA_W'(cfg.bytes_th);
      REG_CALLS_TH: prdata = CFG_DATA_W'(cfg.calls_th);
      REG_ALPHA:    prdata = CFG_DATA_W'(cfg.alpha);
      REG_FACTOR:   prdata = CFG_DATA_W'(cfg.factor);
      REG_WINDOW:   prdata = CFG_DATA_W'(cfg.window_updates);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/artm_ctrl.sv
// sequencer: accept, update, divide, blend, peak check, result
// depends on artm_pkg, drives artm_dp through ctl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module artm_ctrl
  import artm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  ctl_status_t      status,
  output ctl_cmd_t         cmd
);

  localparam int DIV_STEPS = COUNT_WIDTH + 10;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    IDLE, APPLY, DECIDE, DIV_RUN, DIV_END,
    BL0, BL1, BL2, BL3, BL4, PK0, PK1, DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      case (state)
        IDLE:    if (s_tvalid) state <= APPLY;
        APPLY:   state <= DECIDE;
        DECIDE: begin
          step  <= '0;
          state <= status.close_due ? DIV_RUN : PK0;
        end
        DIV_RUN: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) state <= DIV_END;
        end
        DIV_END: state <= BL0;
        BL0:     state <= BL1;
        BL1:     state <= BL2;
        BL2:     state <= BL3;
        BL3:     state <= BL4;
        BL4:     state <= PK0;
        PK0:     state <= PK1;
        PK1:     state <= DONE;
        DONE:    if (status.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_INST_B_ALPHA;
    case (state)
      IDLE:    cmd.take_in = s_tvalid;
      APPLY:   cmd.apply = 1'b1;
      DECIDE:  cmd.div_load = status.close_due;
      DIV_RUN: cmd.div_step = 1'b1;
      DIV_END: cmd.inst_store = 1'b1;
      BL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INST_B_ALPHA;
      end
      BL1: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_SMOOTH_B_BETA;
      end
      BL2: begin
        cmd.smooth_b_store = 1'b1;
        cmd.mul_en         = 1'b1;
        cmd.mul_sel        = MUL_INST_C_ALPHA;
      end
      BL3: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_SMOOTH_C_BETA;
      end
      BL4: begin
        cmd.smooth_c_store = 1'b1;
        cmd.close_win      = 1'b1;
      end
      PK0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SMOOTH_B_FACTOR;
      end
      PK1: begin
        cmd.peak_store = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_SMOOTH_C_FACTOR;
      end
      DONE:    cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/artm_dp.sv
// datapath: totals, window sums, two-lane restoring divider, shared multiplier,
// smoothing, trigger compare and output register; depends on artm_pkg
`timescale 1ns / 1ps
`default_nettype none

module artm_dp
  import artm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  ctl_cmd_t         cmd,
  output ctl_status_t      status,
  input  cfg_t             cfg,
  input  wire logic        in_op,
  input  wire logic [31:0] in_bytes,
  input  wire logic [15:0] in_calls,
  input  wire logic [31:0] in_now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [55:0]      out_data
);

  localparam int W = COUNT_WIDTH;
  localparam int N = COUNT_WIDTH + 10;
  localparam int PW = COUNT_WIDTH + 17;
  localparam logic [W-1:0] CNT_MAX = '1;

  // latched item
  logic        op_reg;
  logic [31:0] badd, now_reg;
  logic [15:0] cadd;

  // state
  logic [W-1:0] total_b, total_c, win_b, win_c;
  logic [W-1:0] inst_b, inst_c, smooth_b, smooth_c;
  logic [15:0]  win_count;
  logic [31:0]  last_ms;
  logic         closed_flag, peak_b;

  // divider
  logic [31:0]  divisor;
  logic [N-1:0] quo_b, quo_c;
  logic [31:0]  rem_b, rem_c;

  // multiplier
  logic [PW-1:0] prod, acc;
  logic [W-1:0]  mul_a;
  logic [16:0]   mul_b;

  logic [W:0]    sum_tb, sum_tc, sum_wb, sum_wc;
  logic [W-1:0]  sat_tb, sat_tc, sat_wb, sat_wc;
  logic [N-1:0]  xb, xc, dvd_b, dvd_c;
  logic [31:0]   elapsed;
  logic [32:0]   sh_b, sh_c;
  logic [33:0]   df_b, df_c;
  logic [W-1:0]  q_sat_b, q_sat_c;
  logic [16:0]   a_eff, b_eff;
  logic [PW:0]   blend_sum;
  logic [W-1:0]  blended;
  logic          peak_now, regular, peak_all;
  logic [63:0]   sb64;
  logic [47:0]   sb_out;

  // saturating accumulation
  assign sum_tb = {1'b0, total_b} + (W+1)'(badd);
  assign sum_tc = {1'b0, total_c} + (W+1)'(cadd);
  assign sum_wb = {1'b0, win_b} + (W+1)'(badd);
  assign sum_wc = {1'b0, win_c} + (W+1)'(cadd);
  assign sat_tb = sum_tb[W] ? CNT_MAX : sum_tb[W-1:0];
  assign sat_tc = sum_tc[W] ? CNT_MAX : sum_tc[W-1:0];
  assign sat_wb = sum_wb[W] ? CNT_MAX : sum_wb[W-1:0];
  assign sat_wc = sum_wc[W] ? CNT_MAX : sum_wc[W-1:0];

  // sum times 1000 as 1024 - 16 - 8
  assign xb    = N'(win_b);
  assign xc    = N'(win_c);
  assign dvd_b = (xb << 10) - (xb << 4) - (xb << 3);
  assign dvd_c = (xc << 10) - (xc << 4) - (xc << 3);

  assign elapsed = now_reg - last_ms;

  assign sh_b = {rem_b, quo_b[N-1]};
  assign sh_c = {rem_c, quo_c[N-1]};
  assign df_b = {1'b0, sh_b} - {2'b00, divisor};
  assign df_c = {1'b0, sh_c} - {2'b00, divisor};

  assign q_sat_b = (|quo_b[N-1:W]) ? CNT_MAX : quo_b[W-1:0];
  assign q_sat_c = (|quo_c[N-1:W]) ? CNT_MAX : quo_c[W-1:0];

  assign a_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign b_eff = ALPHA_ONE - a_eff;

  always_comb begin
    case (cmd.mul_sel)
      MUL_INST_B_ALPHA: begin
        mul_a = inst_b;
        mul_b = a_eff;
      end
      MUL_SMOOTH_B_BETA: begin
        mul_a = smooth_b;
        mul_b = b_eff;
      end
      MUL_INST_C_ALPHA: begin
        mul_a = inst_c;
        mul_b = a_eff;
      end
      MUL_SMOOTH_C_BETA: begin
        mul_a = smooth_c;
        mul_b = b_eff;
      end
      MUL_SMOOTH_B_FACTOR: begin
        mul_a = smooth_b;
        mul_b = 17'(cfg.factor);
      end
      MUL_SMOOTH_C_FACTOR: begin
        mul_a = smooth_c;
        mul_b = 17'(cfg.factor);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // weighted sum over 65536, never above the count range
  assign blend_sum = {1'b0, acc} + {1'b0, prod};
  assign blended   = blend_sum[W+15:16];

  // rate above factor times smoothed, exact in q8
  assign peak_now = PW'({inst_b, 8'h00}) > prod;

  assign regular  = (64'(total_b) >= 64'(cfg.bytes_th)) ||
                    (64'(total_c) >= 64'(cfg.calls_th));
  assign peak_all = peak_b || (PW'({inst_c, 8'h00}) > prod);
  assign sb64     = 64'(smooth_b);
  assign sb_out   = (sb64 > 64'(OUT_MAX)) ? OUT_MAX : sb64[47:0];

  assign status.close_due = !op_reg && (win_count >= cfg.window_updates);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_reg  <= in_op;
      badd    <= in_bytes;
      cadd    <= in_calls;
      now_reg <= in_now;
    end
    if (cmd.div_load) begin
      divisor <= (elapsed == '0) ? 32'd1 : elapsed;
      quo_b   <= dvd_b;
      quo_c   <= dvd_c;
      rem_b   <= '0;
      rem_c   <= '0;
    end else if (cmd.div_step) begin
      rem_b <= df_b[33] ? sh_b[31:0] : df_b[31:0];
      rem_c <= df_c[33] ? sh_c[31:0] : df_c[31:0];
      quo_b <= {quo_b[N-2:0], !df_b[33]};
      quo_c <= {quo_c[N-2:0], !df_c[33]};
    end
    if (cmd.mul_en) prod <= PW'(mul_a * mul_b);
    if (cmd.acc_load) acc <= prod;
    if (cmd.peak_store) peak_b <= peak_now;
    if (cmd.out_load) out_data <= {4'h0, sb_out, closed_flag, peak_all,
                                   regular, regular || peak_all};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_b     <= '0;
      total_c     <= '0;
      win_b       <= '0;
      win_c       <= '0;
      win_count   <= '0;
      last_ms     <= '0;
      inst_b      <= '0;
      inst_c      <= '0;
      smooth_b    <= '0;
      smooth_c    <= '0;
      closed_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take_in) closed_flag <= 1'b0;
      if (cmd.apply) begin
        if (op_reg) begin
          total_b   <= '0;
          total_c   <= '0;
          win_b     <= '0;
          win_c     <= '0;
          win_count <= '0;
          last_ms   <= now_reg;
          inst_b    <= '0;
          inst_c    <= '0;
          smooth_b  <= '0;
          smooth_c  <= '0;
        end else begin
          total_b <= sat_tb;
          total_c <= sat_tc;
          win_b   <= sat_wb;
          win_c   <= sat_wc;
          if (win_count != 16'hFFFF) win_count <= win_count + 16'd1;
        end
      end
      if (cmd.inst_store) begin
        inst_b <= q_sat_b;
        inst_c <= q_sat_c;
      end
      if (cmd.smooth_b_store) smooth_b <= blended;
      if (cmd.smooth_c_store) smooth_c <= blended;
      if (cmd.close_win) begin
        win_b       <= '0;
        win_c       <= '0;
        win_count   <= '0;
        last_ms     <= now_reg;
        closed_flag <= 1'b1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> divisor != '0)
    else $error("divider loaded with zero divisor");

  a_close_restarts: assert property (@(posedge clk) disable iff (rst)
    cmd.close_win |=> (win_count == '0) && (win_b == '0) && (win_c == '0)
                      && closed_flag)
    else $error("window not restarted after close");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && op_reg |=> (total_b == '0) && (smooth_b == '0) && (inst_c == '0)
                            && !status.close_due)
    else $error("clear left state behind");

endmodule

`default_nettype wire

>>> hdl/allocation_rate_trigger_monitor.sv
// Allocation rate trigger monitor, top level.
// Input stream s_*: s_tuser = op (0 update, 1 clear); s_tdata = bytes_added,
// calls_added, now_ms. Output stream m_*: one result per input item.
// Configuration through the apb-style port, 64-bit registers at 8*index.
// An update adds to saturating totals and window sums; every window_updates
// updates the window closes: rates = sum*1000/elapsed ms, smoothed with alpha.
// Without a window close an item passes through the update, the peak check
// and the output register; the next item is taken once the result is loaded.
// A window close adds the divider, which retires one quotient bit per cycle
// for both rates at once, then a step to store the rates and the
// multiply-accumulate steps on the shared multiplier.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and the
// next finished result waits until the held one is taken.
// Reset (rst, synchronous) clears all counters and rates, empties the output
// and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module allocation_rate_trigger_monitor
  import artm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [79:0]           s_tdata,  // bytes_added, calls_added, now_ms
  input  wire logic                  s_tuser,  // op
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // trigger, threshold_hit, spike_hit, window_closed, smoothed_bytes_rate
  output logic [55:0]                m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t        cfg;
  ctl_cmd_t    cmd;
  ctl_status_t status;

  artm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  artm_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  artm_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .in_op     (s_tuser),
    .in_bytes  (s_tdata[31:0]),
    .in_calls  (s_tdata[47:32]),
    .in_now    (s_tdata[79:48]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
